// ===== hw/rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants for the point-in-polygon crossing-number test: default
// coordinate and crossing-count widths used by the top level and channels.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Signed fixed-point coordinate width
  localparam int COORD_BITS_DEF = 16;

  // Saturating crossing counter width
  localparam int COUNT_BITS_DEF = 10;

endpackage : pip_pkg

// ===== hw/rtl/pip_vertex_if.sv =====
// ----------------------------------------------------------------------------
// pip_vertex_if
// Vertex channel: one beat is one polygon vertex, the query point and the
// first/last markers, under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_vertex_if #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
);

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic                         first_vertex;
  logic                         last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, query_x, query_y, first_vertex, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, vertex_x, vertex_y, query_x, query_y, first_vertex, last_vertex,
    output ready
  );

endinterface : pip_vertex_if

// ===== hw/rtl/pip_result_if.sv =====
// ----------------------------------------------------------------------------
// pip_result_if
// Result channel: one beat per closed polygon, carrying the inside bit and
// the saturated crossing count, under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_result_if #(
  parameter int COUNT_BITS = pip_pkg::COUNT_BITS_DEF
);

  logic                  valid;
  logic                  ready;
  logic                  inside_res;
  logic [COUNT_BITS-1:0] crossings;

  modport source (
    output valid, inside_res, crossings,
    input  ready
  );

  modport sink (
    input  valid, inside_res, crossings,
    output ready
  );

endinterface : pip_result_if

// ===== hw/rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test. Vertices stream in one per beat;
// each beat tests the edge from the previous vertex and, on the last vertex,
// the closing edge back to the first. A result beat goes out per polygon.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   -------  ---  ------------  ---------------------------------------------
//   vtx      in   valid/ready   vertex_x, vertex_y, query_x, query_y,
//                               first_vertex, last_vertex
//   res      out  valid/ready   inside_res, crossings
//
// One vertex beat per cycle while no stalled result blocks the product stage. A
// last vertex reaches its result via input register, product register, result reg.
// The two 17x17-bit signed products per edge set the per-stage path.
// Synchronous active-high reset clears the polygon state to a polygon at
// (0,0) with query point (0,0), zero count and even parity.
// A stalled result only holds back the pipeline behind it once a later last
// vertex reaches the product stage; beats without last keep flowing.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pip_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pip_vertex_if.sink   vtx,
  pip_result_if.source res
);

  localparam int DiffBits = COORD_BITS + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // One edge with the query point it is tested against
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
  } edge_t;

  // Edge after range checks and cross products
  typedef struct packed {
    logic                       qual;
    logic                       dy_pos;
    logic signed [ProdBits-1:0] p1;
    logic signed [ProdBits-1:0] p2;
  } prod_t;

  // Range checks and the two cross products of one edge
  function automatic prod_t edge_prod(edge_t e);
    logic signed [DiffBits-1:0]   dy;
    logic signed [DiffBits-1:0]   dx;
    logic signed [DiffBits-1:0]   ox;
    logic signed [DiffBits-1:0]   oy;
    logic signed [COORD_BITS-1:0] ylo;
    logic signed [COORD_BITS-1:0] yhi;
    logic signed [COORD_BITS-1:0] xhi;
    prod_t                        r;
    dy       = DiffBits'(e.y2) - DiffBits'(e.y1);
    dx       = DiffBits'(e.x2) - DiffBits'(e.x1);
    ox       = DiffBits'(e.tx) - DiffBits'(e.x1);
    oy       = DiffBits'(e.ty) - DiffBits'(e.y1);
    ylo      = (e.y1 < e.y2) ? e.y1 : e.y2;
    yhi      = (e.y1 < e.y2) ? e.y2 : e.y1;
    xhi      = (e.x1 < e.x2) ? e.x2 : e.x1;
    r.qual   = (dy != '0) && (e.ty > ylo) && (e.ty <= yhi) && (e.tx <= xhi);
    r.dy_pos = ~dy[DiffBits-1];
    r.p1     = ox * dy;
    r.p2     = oy * dx;
    return r;
  endfunction

  // Crossing decision from registered products
  function automatic logic edge_hit(prod_t p);
    logic le;
    logic ge;
    le = (p.p1 <= p.p2);
    ge = (p.p1 >= p.p2);
    return p.qual && (p.dy_pos ? le : ge);
  endfunction

  // Polygon state
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] test_x;
  logic signed [COORD_BITS-1:0] test_y;
  logic                         parity;
  logic [COUNT_BITS-1:0]        cross_count;

  // Input register stage
  logic  s1_valid;
  logic  s1_first;
  logic  s1_last;
  edge_t s1_edge_a;
  edge_t s1_edge_b;

  // Product register stage
  logic  s2_valid;
  logic  s2_first;
  logic  s2_last;
  prod_t s2_prod_a;
  prod_t s2_prod_b;

  // Result register
  logic                  out_valid;
  logic                  out_inside;
  logic [COUNT_BITS-1:0] out_count;

  logic                         in_acc;
  logic                         ready1;
  logic                         ready2;
  logic                         retire2;
  logic signed [COORD_BITS-1:0] test_x_next;
  logic signed [COORD_BITS-1:0] test_y_next;
  logic signed [COORD_BITS-1:0] start_x_next;
  logic signed [COORD_BITS-1:0] start_y_next;
  prod_t                        prod_a;
  prod_t                        prod_b;
  logic                         hit_a;
  logic                         hit_b;
  logic [COUNT_BITS-1:0]        count_base;
  logic [COUNT_BITS:0]          count_sum;
  logic [COUNT_BITS-1:0]        cross_count_next;
  logic                         parity_next;

  // Handshake: each stage moves when the one after it has room
  assign ready2  = !s2_valid || !s2_last || !out_valid || res.ready;
  assign ready1  = !s1_valid || ready2;
  assign retire2 = s2_valid && ready2;
  assign in_acc  = vtx.valid && ready1;

  assign vtx.ready      = ready1;
  assign res.valid      = out_valid;
  assign res.inside_res = out_inside;
  assign res.crossings  = out_count;

  // Query point and start vertex as seen by this beat
  assign test_x_next  = vtx.first_vertex ? vtx.query_x  : test_x;
  assign test_y_next  = vtx.first_vertex ? vtx.query_y  : test_y;
  assign start_x_next = vtx.first_vertex ? vtx.vertex_x : start_x;
  assign start_y_next = vtx.first_vertex ? vtx.vertex_y : start_y;

  // Polygon geometry state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      test_x  <= '0;
      test_y  <= '0;
    end else if (in_acc) begin
      start_x <= start_x_next;
      start_y <= start_y_next;
      test_x  <= test_x_next;
      test_y  <= test_y_next;
      prev_x  <= vtx.vertex_x;
      prev_y  <= vtx.vertex_y;
    end
  end

  // Input register: edge from previous vertex and closing edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_acc;
    end
    if (in_acc) begin
      s1_first  <= vtx.first_vertex;
      s1_last   <= vtx.last_vertex;
      s1_edge_a <= '{x1: prev_x, y1: prev_y, x2: vtx.vertex_x, y2: vtx.vertex_y,
                     tx: test_x, ty: test_y};
      s1_edge_b <= '{x1: vtx.vertex_x, y1: vtx.vertex_y, x2: start_x_next,
                     y2: start_y_next, tx: test_x_next, ty: test_y_next};
    end
  end

  // Range checks and cross products
  always_comb begin
    prod_a      = edge_prod(s1_edge_a);
    prod_b      = edge_prod(s1_edge_b);
    prod_a.qual = prod_a.qual && !s1_first;
    prod_b.qual = prod_b.qual && s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
    if (ready2 && s1_valid) begin
      s2_first  <= s1_first;
      s2_last   <= s1_last;
      s2_prod_a <= prod_a;
      s2_prod_b <= prod_b;
    end
  end

  // Crossing decisions and saturating count update
  always_comb begin
    hit_a       = edge_hit(s2_prod_a);
    hit_b       = edge_hit(s2_prod_b);
    count_base  = s2_first ? '0 : cross_count;
    count_sum   = {1'b0, count_base} + (COUNT_BITS+1)'(hit_a) + (COUNT_BITS+1)'(hit_b);
    cross_count_next = count_sum[COUNT_BITS] ? CountMax : count_sum[COUNT_BITS-1:0];
    parity_next = (s2_first ? 1'b0 : parity) ^ hit_a ^ hit_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_count <= '0;
      parity      <= 1'b0;
    end else if (retire2) begin
      cross_count <= cross_count_next;
      parity      <= parity_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire2 && s2_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (retire2 && s2_last) begin
      out_inside <= parity_next;
      out_count  <= cross_count_next;
    end
  end

  // A result beat appears only after a last vertex leaves the product stage
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid && s2_last))
    else $error("result beat without a last vertex");

  // Below saturation the parity tracks the count's low bit
  a_parity_count: assert property (@(posedge clk) disable iff (rst)
    (cross_count != CountMax) |-> (parity == cross_count[0]))
    else $error("parity out of step with crossing count");

  // Count never drops within one polygon
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (retire2 && !s2_first) |=> (cross_count >= $past(cross_count)))
    else $error("crossing count decreased within a polygon");

  // A single-vertex polygon has no crossings
  a_single_vertex: assert property (@(posedge clk) disable iff (rst)
    (retire2 && s2_first && s2_last) |=> (out_count == '0 && !out_inside))
    else $error("single-vertex polygon reported crossings");

endmodule : point_in_polygon_test

// ===== dv/pip_parity_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_parity_check
// Watches the vertex and result channels of the point-in-polygon block. Every
// accepted vertex beat runs through an independent crossing-number model; a
// last-vertex beat queues the inside bit and the saturated crossing count,
// which are compared against the next accepted result beat.
// ----------------------------------------------------------------------------
module pip_parity_check (
  input  logic  clk,
  input  logic  rst,
  pip_vertex_if vtx,
  pip_result_if res,
  output int    fail_count,
  output int    pending_verdicts
);

  typedef logic signed [pip_pkg::COORD_BITS_DEF-1:0] coord_t;
  typedef logic [pip_pkg::COUNT_BITS_DEF-1:0]        count_t;

  typedef struct packed {
    logic   in_poly;
    count_t crossings;
  } verdict_t;

  // Polygon state as seen from the vertex stream
  coord_t anchor_x, anchor_y;  // first vertex of the polygon
  coord_t last_x, last_y;      // vertex of the previous beat
  coord_t point_x, point_y;    // query point
  logic   inside_q;
  count_t cross_q;

  verdict_t expected_verdicts[$];

  // Ray to +x from the query point against edge (x1,y1)-(x2,y2), exact form
  function automatic bit edge_crossed(input longint x1, input longint y1,
                                      input longint x2, input longint y2);
    longint tx, ty, ylo, yhi, xhi, dy, dx, lhs, rhs;
    tx  = point_x;
    ty  = point_y;
    ylo = (y1 < y2) ? y1 : y2;
    yhi = (y1 < y2) ? y2 : y1;
    xhi = (x1 < x2) ? x2 : x1;
    dy  = y2 - y1;
    dx  = x2 - x1;
    if (dy == 0 || ty <= ylo || ty > yhi || tx > xhi) return 1'b0;
    lhs = (tx - x1) * dy;
    rhs = (ty - y1) * dx;
    return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  // Parity always flips on a crossing; the count holds at all ones
  task automatic tally(input bit hit);
    if (hit) begin
      inside_q = ~inside_q;
      if (cross_q != '1) cross_q = cross_q + 1'b1;
    end
  endtask

  task automatic absorb_vertex(input coord_t vx, input coord_t vy,
                               input coord_t qx, input coord_t qy,
                               input bit first, input bit last);
    verdict_t v;
    if (first) begin
      point_x  = qx;
      point_y  = qy;
      anchor_x = vx;
      anchor_y = vy;
      inside_q = 1'b0;
      cross_q  = '0;
    end else begin
      tally(edge_crossed(last_x, last_y, vx, vy));
    end
    last_x = vx;
    last_y = vy;
    if (last) begin
      // closing edge back to the first vertex
      tally(edge_crossed(vx, vy, anchor_x, anchor_y));
      v.in_poly   = inside_q;
      v.crossings = cross_q;
      expected_verdicts.push_back(v);
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin : track
    verdict_t want;
    if (rst) begin
      anchor_x = '0;
      anchor_y = '0;
      last_x   = '0;
      last_y   = '0;
      point_x  = '0;
      point_y  = '0;
      inside_q = 1'b0;
      cross_q  = '0;
      expected_verdicts.delete();
    end else begin
      if (vtx.valid && vtx.ready) begin
        absorb_vertex(vtx.vertex_x, vtx.vertex_y, vtx.query_x, vtx.query_y,
                      vtx.first_vertex, vtx.last_vertex);
      end
      if (res.valid && res.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with nothing expected: inside_res %0d crossings %0d",
                 res.inside_res, res.crossings);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (res.inside_res !== want.in_poly) begin
            $error("inside_res mismatch: expected %0d, actual %0d",
                   want.in_poly, res.inside_res);
            fail_count++;
          end
          if (res.crossings !== want.crossings) begin
            $error("crossings mismatch: expected %0d, actual %0d",
                   want.crossings, res.crossings);
            fail_count++;
          end
        end
      end
    end
    pending_verdicts <= expected_verdicts.size();
  end

endmodule : pip_parity_check

// ===== dv/point_in_polygon_test_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_test
// Stimulus and verdict for the point-in-polygon block: directed polygons
// (extreme coordinates, single-vertex polygons, vertices before the first
// polygon, continuation after a last vertex, points on edges), one zigzag
// that crosses on every edge but a flat closing edge, then random polygons mixed with stray beats,
// under random gaps on the vertex side and stalls on results.
// ----------------------------------------------------------------------------
module point_in_polygon_test_test;

  typedef logic signed [pip_pkg::COORD_BITS_DEF-1:0] coord_t;

  localparam coord_t CMAX = coord_t'(16'sh7fff);
  localparam coord_t CMIN = coord_t'(16'sh8000);

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_verdicts;
  int   beats_sent;
  bit   no_idle;

  pip_vertex_if #(.COORD_BITS(pip_pkg::COORD_BITS_DEF)) vtx_ch ();
  pip_result_if #(.COUNT_BITS(pip_pkg::COUNT_BITS_DEF)) res_ch ();

  point_in_polygon_test #(
    .COORD_BITS (pip_pkg::COORD_BITS_DEF),
    .COUNT_BITS (pip_pkg::COUNT_BITS_DEF)
  ) dut (
    .clk (clk),
    .rst (rst),
    .vtx (vtx_ch),
    .res (res_ch)
  );

  pip_parity_check u_parity_check (
    .clk              (clk),
    .rst              (rst),
    .vtx              (vtx_ch),
    .res              (res_ch),
    .fail_count       (fail_count),
    .pending_verdicts (pending_verdicts)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One vertex beat, after an optional idle gap
  task automatic send_vertex(input coord_t x, input coord_t y,
                             input coord_t qx, input coord_t qy,
                             input bit first, input bit last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      vtx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_ch.valid        <= 1'b1;
    vtx_ch.vertex_x     <= x;
    vtx_ch.vertex_y     <= y;
    vtx_ch.query_x      <= qx;
    vtx_ch.query_y      <= qy;
    vtx_ch.first_vertex <= first;
    vtx_ch.last_vertex  <= last;
    do @(posedge clk); while (!vtx_ch.ready);
    beats_sent++;
  endtask

  // Coordinate near the query, anywhere, or on an extreme / aligned value
  function automatic coord_t pick_coord(input coord_t q);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return q + coord_t'($urandom_range(0, 16)) - coord_t'(8);
    if (r < 50) return q + coord_t'($urandom_range(0, 600)) - coord_t'(300);
    if (r < 80) return coord_t'($urandom);
    case ($urandom_range(0, 4))
      0:       return CMAX;
      1:       return CMIN;
      2:       return q + coord_t'(1);
      3:       return q - coord_t'(1);
      default: return q;
    endcase
  endfunction

  // Well-formed polygon of n vertices; query fields are junk after the first
  task automatic send_polygon(input int n);
    coord_t qx, qy;
    if ($urandom_range(0, 9) == 0) begin
      qx = $urandom_range(0, 1) ? CMAX : CMIN;
      qy = $urandom_range(0, 1) ? CMAX : CMIN;
    end else begin
      qx = coord_t'($urandom);
      qy = coord_t'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        send_vertex(pick_coord(qx), pick_coord(qy), qx, qy, 1'b1, n == 1);
      else
        send_vertex(pick_coord(qx), pick_coord(qy), coord_t'($urandom),
                    coord_t'($urandom), 1'b0, i == n - 1);
    end
  endtask

  // Result side: ready runs broken by random stalls, with calm stretches
  initial begin
    res_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(50, 200)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
      if (pick_gap() > 0) begin
        res_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int zig_len;
    int base;
    rst                 <= 1'b1;
    vtx_ch.valid        <= 1'b0;
    vtx_ch.vertex_x     <= '0;
    vtx_ch.vertex_y     <= '0;
    vtx_ch.query_x      <= '0;
    vtx_ch.query_y      <= '0;
    vtx_ch.first_vertex <= 1'b0;
    vtx_ch.last_vertex  <= 1'b0;
    beats_sent = 0;
    no_idle    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // vertices before any first beat: polygon from (0,0), query (0,0)
    send_vertex(16'sd10, 16'sd5, CMAX, CMIN, 1'b0, 1'b0);
    send_vertex(16'sd10, -16'sd5, CMIN, CMAX, 1'b0, 1'b1);
    // single vertex that is first and last
    send_vertex(CMAX, CMIN, CMIN, CMAX, 1'b1, 1'b1);
    // continuation after a last beat with no new first
    send_vertex(-16'sd20, 16'sd40, '0, '0, 1'b0, 1'b0);
    send_vertex(-16'sd20, -16'sd40, '0, '0, 1'b0, 1'b1);
    // full-range square, query at center and then on a corner
    send_vertex(CMIN, CMIN, '0, '0, 1'b1, 1'b0);
    send_vertex(CMAX, CMIN, '0, '0, 1'b0, 1'b0);
    send_vertex(CMAX, CMAX, '0, '0, 1'b0, 1'b0);
    send_vertex(CMIN, CMAX, '0, '0, 1'b0, 1'b1);
    send_vertex(CMIN, CMIN, CMAX, CMAX, 1'b1, 1'b0);
    send_vertex(CMAX, CMIN, '0, '0, 1'b0, 1'b0);
    send_vertex(CMAX, CMAX, '0, '0, 1'b0, 1'b0);
    send_vertex(CMIN, CMAX, '0, '0, 1'b0, 1'b1);
    // query exactly on a diagonal edge
    send_vertex(-16'sd10, -16'sd10, '0, '0, 1'b1, 1'b0);
    send_vertex(16'sd10, 16'sd10, '0, '0, 1'b0, 1'b0);
    send_vertex(16'sd10, -16'sd10, '0, '0, 1'b0, 1'b1);
    // horizontal edges with query on the top y, then query right of max x
    send_vertex(-16'sd5, 16'sd0, '0, 16'sd8, 1'b1, 1'b0);
    send_vertex(16'sd5, 16'sd0, '0, '0, 1'b0, 1'b0);
    send_vertex(16'sd5, 16'sd8, '0, '0, 1'b0, 1'b0);
    send_vertex(-16'sd5, 16'sd8, '0, '0, 1'b0, 1'b1);
    send_vertex(-16'sd5, 16'sd0, 16'sd9, 16'sd4, 1'b1, 1'b0);
    send_vertex(16'sd5, 16'sd0, '0, '0, 1'b0, 1'b0);
    send_vertex(16'sd5, 16'sd8, '0, '0, 1'b0, 1'b0);
    send_vertex(-16'sd5, 16'sd8, '0, '0, 1'b0, 1'b1);

    // zigzag right of the query: every edge but a flat closing edge crosses, back to back
    no_idle = 1'b1;
    zig_len = 120 + $urandom_range(0, 1);
    for (int i = 0; i < zig_len; i++) begin
      send_vertex(coord_t'($urandom_range(1, 32767)),
                  (i % 2 == 0) ? 16'sd10 : -16'sd10,
                  '0, '0, i == 0, i == zig_len - 1);
    end

    // random polygons mixed with stray beats
    base = beats_sent;
    while (beats_sent < base + 400) begin
      no_idle = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 12)
        send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 19) == 0)
        send_polygon($urandom_range(11, 40));
      else
        send_polygon($urandom_range(1, 10));
    end
    vtx_ch.valid <= 1'b0;

    // drain, then allow for the pipeline depth
    do @(posedge clk); while (pending_verdicts != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule : point_in_polygon_test_test

// ===== filelist.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_vertex_if.sv
hw/rtl/pip_result_if.sv
hw/rtl/point_in_polygon_test.sv
dv/pip_parity_check.sv
dv/point_in_polygon_test_test.sv
